// ===== rtl/rtn_pkg.sv =====
// ---------------------------------------------------------------------------
// rtn_pkg
// shared types and constants for the regex to nfa builder
// ---------------------------------------------------------------------------
`default_nettype none

package rtn_pkg;

   localparam int OP_STACK_DEPTH_DEF   = 8;
   localparam int FRAG_STACK_DEPTH_DEF = 16;
   localparam int MAX_STATES_DEF       = 1024;
   localparam int QUEUE_DEPTH          = 4;
   localparam int OUT_STATE_W          = 11;
   localparam int EDGE_LIMIT           = 63;

   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_ALT    = 8'h7C;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_OVERFLOW  = 2'd1;
   localparam logic [1:0] ST_MALFORMED = 2'd2;

   typedef enum logic [1:0] {
      OP_LPAREN = 2'd0,
      OP_ALT    = 2'd1,
      OP_CAT    = 2'd2,
      OP_STAR   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      CLS_LIT,
      CLS_LPAREN,
      CLS_RPAREN,
      CLS_ALT,
      CLS_STAR
   } cls_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
      logic       cat;
      cls_type    cls;
   } item_type;

   typedef struct packed {
      logic                   emit;
      logic                   finish;
      logic                   kind;
      logic [OUT_STATE_W-1:0] from_state;
      logic [OUT_STATE_W-1:0] to_state;
      logic [7:0]             symbol;
      logic                   is_epsilon;
      logic [1:0]             status;
   } res_type;

endpackage

`default_nettype wire

// ===== rtl/rtn_ram.sv =====
// ---------------------------------------------------------------------------
// rtn_ram
// generic single write, single read ram with registered read data
// ---------------------------------------------------------------------------
`default_nettype none

module rtn_ram #(
   parameter int WIDTH = 22,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/rtn_queue.sv =====
// ---------------------------------------------------------------------------
// rtn_queue
// short fifo of classified characters between front and back
// ---------------------------------------------------------------------------
`default_nettype none

module rtn_queue #(
   parameter int DEPTH = 4
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire rtn_pkg::item_type push_item,
   input  wire logic              pop,
   output      logic              full,
   output      logic              not_empty,
   output      rtn_pkg::item_type head
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   rtn_pkg::item_type mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign full      = (cnt_ff == CW'(DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign head      = mem_ff[rd_ptr_ff];

endmodule

`default_nettype wire

// ===== rtl/rtn_front.sv =====
// ---------------------------------------------------------------------------
// rtn_front
// accepts characters, classifies them and flags implicit concatenation
// ---------------------------------------------------------------------------
`default_nettype none

module rtn_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic [7:0]        req_ch,
   input  wire logic              req_last,
   output      logic              req_stall,
   input  wire logic              q_full,
   output      logic              q_push,
   output      rtn_pkg::item_type q_item
);

   logic [7:0] prev_ff, prev_in;
   logic       have_prev_ff, have_prev_in;

   always_comb begin
      q_item.ch   = req_ch;
      q_item.last = req_last;
      case (req_ch)
         rtn_pkg::CH_LPAREN: q_item.cls = rtn_pkg::CLS_LPAREN;
         rtn_pkg::CH_RPAREN: q_item.cls = rtn_pkg::CLS_RPAREN;
         rtn_pkg::CH_ALT:    q_item.cls = rtn_pkg::CLS_ALT;
         rtn_pkg::CH_STAR:   q_item.cls = rtn_pkg::CLS_STAR;
         default:            q_item.cls = rtn_pkg::CLS_LIT;
      endcase
      q_item.cat = have_prev_ff
         && !(prev_ff inside {rtn_pkg::CH_LPAREN, rtn_pkg::CH_ALT})
         && !(req_ch inside {rtn_pkg::CH_RPAREN, rtn_pkg::CH_ALT, rtn_pkg::CH_STAR});
      q_push       = req_valid && !q_full;
      prev_in      = prev_ff;
      have_prev_in = have_prev_ff;
      if (q_push) begin
         prev_in      = req_ch;
         have_prev_in = !req_last;
      end
   end

   assign req_stall = q_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff      <= '0;
         have_prev_ff <= 1'b0;
      end else begin
         prev_ff      <= prev_in;
         have_prev_ff <= have_prev_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/rtn_back.sv =====
// ---------------------------------------------------------------------------
// rtn_back
// operator stack and thompson construction sequencer, emits nfa edges
// ---------------------------------------------------------------------------
`default_nettype none

module rtn_back #(
   parameter int OP_STACK_DEPTH   = rtn_pkg::OP_STACK_DEPTH_DEF,
   parameter int FRAG_STACK_DEPTH = rtn_pkg::FRAG_STACK_DEPTH_DEF,
   parameter int MAX_STATES       = rtn_pkg::MAX_STATES_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_valid,
   input  wire rtn_pkg::item_type q_head,
   output      logic              q_pop,
   input  wire logic              sink_ok,
   output      rtn_pkg::res_type  res
);

   localparam int OW  = $clog2(OP_STACK_DEPTH + 1);
   localparam int OAW = $clog2(OP_STACK_DEPTH);
   localparam int FW  = $clog2(FRAG_STACK_DEPTH + 1);
   localparam int FAW = $clog2(FRAG_STACK_DEPTH);
   localparam int SW  = $clog2(MAX_STATES + 1);
   localparam int OSW = rtn_pkg::OUT_STATE_W;

   typedef enum logic [3:0] {
      S_IDLE, S_CHAR, S_LOOP, S_LOOPEND, S_APPLY, S_RD1, S_RD2,
      S_EDGE, S_POST, S_CHKF, S_RPT, S_FIN
   } state_type;

   typedef enum logic [2:0] {M_CAT, M_ALT, M_STAR, M_RP, M_FIN} mode_type;
   typedef enum logic [1:0] {EK_LIT, EK_STAR, EK_CAT, EK_ALT} ek_type;

   state_type         state_ff, state_in;
   mode_type          mode_ff, mode_in;
   ek_type            ek_ff, ek_in;
   rtn_pkg::op_type   cur_op_ff, cur_op_in;
   rtn_pkg::item_type item_ff, item_in;
   rtn_pkg::op_type   op_stk_ff [OP_STACK_DEPTH];
   rtn_pkg::op_type   op_stk_in [OP_STACK_DEPTH];
   logic [OW-1:0]     opc_ff, opc_in;
   logic [FW-1:0]     fc_ff, fc_in;
   logic [SW-1:0]     sc_ff, sc_in;
   logic [1:0]        err_ff, err_in;
   logic [5:0]        ecnt_ff, ecnt_in;
   logic [1:0]        k_ff, k_in;
   logic [SW-1:0]     s_ff, s_in, e_ff, e_in;
   logic [SW-1:0]     as_ff, as_in, ae_ff, ae_in;
   logic [SW-1:0]     bs_ff, bs_in, be_ff, be_in;

   logic              wr_en, rd_en;
   logic [FAW-1:0]    wr_addr, rd_addr;
   logic [2*SW-1:0]   wr_data, rd_data;

   logic [OW-1:0]     opm1;
   logic [FW-1:0]     fcm1, fcm2;
   rtn_pkg::op_type   top_op;
   logic [SW:0]       sc_plus2;
   logic              sc_over;
   logic              cont;
   logic [SW-1:0]     ef, et;
   logic [7:0]        esym;
   logic              eeps, elast;
   logic [SW+OSW-1:0] f_wide, t_wide;
   state_type         ret_state;

   rtn_ram #(.WIDTH(2 * SW), .DEPTH(FRAG_STACK_DEPTH)) u_frag_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      opm1     = opc_ff - OW'(1);
      fcm1     = fc_ff - FW'(1);
      fcm2     = fc_ff - FW'(2);
      top_op   = op_stk_ff[opm1[OAW-1:0]];
      sc_plus2 = {1'b0, sc_ff} + (SW + 1)'(2);
      sc_over  = sc_plus2 > (SW + 1)'(MAX_STATES);
      case (mode_ff)
         M_CAT:   cont = (top_op inside {rtn_pkg::OP_CAT, rtn_pkg::OP_STAR});
         M_ALT:   cont = (top_op != rtn_pkg::OP_LPAREN);
         M_STAR:  cont = (top_op == rtn_pkg::OP_STAR);
         default: cont = (top_op != rtn_pkg::OP_LPAREN);
      endcase
      cont = cont && (err_ff == rtn_pkg::ST_OK) && (opc_ff != '0);

      // current edge of the fragment being built
      esym  = '0;
      eeps  = 1'b1;
      elast = 1'b0;
      ef    = s_ff;
      et    = e_ff;
      case (ek_ff)
         EK_LIT: begin
            esym  = item_ff.ch;
            eeps  = 1'b0;
            elast = 1'b1;
         end
         EK_CAT: begin
            ef    = ae_ff;
            et    = bs_ff;
            elast = 1'b1;
         end
         EK_STAR: begin
            elast = (k_ff == 2'd3);
            case (k_ff)
               2'd0:    begin ef = s_ff;  et = as_ff; end
               2'd1:    begin ef = s_ff;  et = e_ff;  end
               2'd2:    begin ef = ae_ff; et = e_ff;  end
               default: begin ef = ae_ff; et = as_ff; end
            endcase
         end
         default: begin
            elast = (k_ff == 2'd3);
            case (k_ff)
               2'd0:    begin ef = s_ff;  et = as_ff; end
               2'd1:    begin ef = s_ff;  et = bs_ff; end
               2'd2:    begin ef = ae_ff; et = e_ff;  end
               default: begin ef = be_ff; et = e_ff;  end
            endcase
         end
      endcase
      ret_state = (ek_ff == EK_LIT) ? S_POST : S_LOOP;

      state_in  = state_ff;
      mode_in   = mode_ff;
      ek_in     = ek_ff;
      cur_op_in = cur_op_ff;
      item_in   = item_ff;
      op_stk_in = op_stk_ff;
      opc_in    = opc_ff;
      fc_in     = fc_ff;
      sc_in     = sc_ff;
      err_in    = err_ff;
      ecnt_in   = ecnt_ff;
      k_in      = k_ff;
      s_in      = s_ff;
      e_in      = e_ff;
      as_in     = as_ff;
      ae_in     = ae_ff;
      bs_in     = bs_ff;
      be_in     = be_ff;
      q_pop     = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = fc_ff[FAW-1:0];
      wr_data   = {s_ff, e_ff};
      rd_en     = 1'b0;
      rd_addr   = fcm1[FAW-1:0];
      res       = '0;
      f_wide    = {{OSW{1'b0}}, ef};
      t_wide    = {{OSW{1'b0}}, et};

      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop   = 1'b1;
               item_in = q_head;
               ecnt_in = '0;
               if (err_ff != rtn_pkg::ST_OK) begin
                  state_in = S_POST;
               end else if (q_head.cat) begin
                  mode_in  = M_CAT;
                  state_in = S_LOOP;
               end else begin
                  state_in = S_CHAR;
               end
            end
         end
         S_CHAR: begin
            state_in = S_POST;
            if (err_ff == rtn_pkg::ST_OK) begin
               case (item_ff.cls)
                  rtn_pkg::CLS_LPAREN: begin
                     if (opc_ff >= OW'(OP_STACK_DEPTH)) begin
                        err_in = rtn_pkg::ST_OVERFLOW;
                     end else begin
                        op_stk_in[opc_ff[OAW-1:0]] = rtn_pkg::OP_LPAREN;
                        opc_in = opc_ff + OW'(1);
                     end
                  end
                  rtn_pkg::CLS_RPAREN: begin
                     mode_in  = M_RP;
                     state_in = S_LOOP;
                  end
                  rtn_pkg::CLS_ALT: begin
                     mode_in  = M_ALT;
                     state_in = S_LOOP;
                  end
                  rtn_pkg::CLS_STAR: begin
                     mode_in  = M_STAR;
                     state_in = S_LOOP;
                  end
                  default: begin
                     if (fc_ff >= FW'(FRAG_STACK_DEPTH) || sc_over) begin
                        err_in = rtn_pkg::ST_OVERFLOW;
                     end else begin
                        s_in     = sc_ff + SW'(1);
                        e_in     = sc_plus2[SW-1:0];
                        sc_in    = sc_plus2[SW-1:0];
                        wr_en    = 1'b1;
                        wr_data  = {sc_ff + SW'(1), sc_plus2[SW-1:0]};
                        fc_in    = fc_ff + FW'(1);
                        ek_in    = EK_LIT;
                        k_in     = '0;
                        state_in = S_EDGE;
                     end
                  end
               endcase
            end
         end
         S_LOOP: begin
            if (cont) begin
               opc_in    = opm1;
               cur_op_in = top_op;
               state_in  = S_APPLY;
            end else begin
               state_in = S_LOOPEND;
            end
         end
         S_LOOPEND: begin
            case (mode_ff)
               M_RP: begin
                  state_in = S_POST;
                  if (err_ff == rtn_pkg::ST_OK) begin
                     if (opc_ff == '0) begin
                        err_in = rtn_pkg::ST_MALFORMED;
                     end else begin
                        opc_in = opm1;
                     end
                  end
               end
               M_FIN: begin
                  state_in = S_CHKF;
                  if (err_ff == rtn_pkg::ST_OK && opc_ff != '0) begin
                     err_in = rtn_pkg::ST_MALFORMED;
                  end
               end
               default: begin
                  state_in = (mode_ff == M_CAT) ? S_CHAR : S_POST;
                  if (err_ff == rtn_pkg::ST_OK) begin
                     if (opc_ff >= OW'(OP_STACK_DEPTH)) begin
                        err_in = rtn_pkg::ST_OVERFLOW;
                     end else begin
                        opc_in = opc_ff + OW'(1);
                        case (mode_ff)
                           M_CAT:   op_stk_in[opc_ff[OAW-1:0]] = rtn_pkg::OP_CAT;
                           M_ALT:   op_stk_in[opc_ff[OAW-1:0]] = rtn_pkg::OP_ALT;
                           default: op_stk_in[opc_ff[OAW-1:0]] = rtn_pkg::OP_STAR;
                        endcase
                     end
                  end
               end
            endcase
         end
         S_APPLY: begin
            state_in = S_LOOP;
            case (cur_op_ff)
               rtn_pkg::OP_STAR: begin
                  if (fc_ff == '0) begin
                     err_in = rtn_pkg::ST_MALFORMED;
                  end else if (sc_over) begin
                     err_in = rtn_pkg::ST_OVERFLOW;
                  end else begin
                     s_in     = sc_ff + SW'(1);
                     e_in     = sc_plus2[SW-1:0];
                     sc_in    = sc_plus2[SW-1:0];
                     rd_en    = 1'b1;
                     ek_in    = EK_STAR;
                     state_in = S_RD1;
                  end
               end
               rtn_pkg::OP_CAT: begin
                  if (fc_ff < FW'(2)) begin
                     err_in = rtn_pkg::ST_MALFORMED;
                  end else begin
                     rd_en    = 1'b1;
                     ek_in    = EK_CAT;
                     state_in = S_RD1;
                  end
               end
               rtn_pkg::OP_ALT: begin
                  if (fc_ff < FW'(2)) begin
                     err_in = rtn_pkg::ST_MALFORMED;
                  end else if (sc_over) begin
                     err_in = rtn_pkg::ST_OVERFLOW;
                  end else begin
                     s_in     = sc_ff + SW'(1);
                     e_in     = sc_plus2[SW-1:0];
                     sc_in    = sc_plus2[SW-1:0];
                     rd_en    = 1'b1;
                     ek_in    = EK_ALT;
                     state_in = S_RD1;
                  end
               end
               default: begin
                  state_in = S_LOOP;
               end
            endcase
         end
         S_RD1: begin
            k_in = '0;
            if (ek_ff == EK_STAR) begin
               as_in    = rd_data[2*SW-1:SW];
               ae_in    = rd_data[SW-1:0];
               wr_en    = 1'b1;
               wr_addr  = fcm1[FAW-1:0];
               wr_data  = {s_ff, e_ff};
               state_in = S_EDGE;
            end else begin
               bs_in    = rd_data[2*SW-1:SW];
               be_in    = rd_data[SW-1:0];
               rd_en    = 1'b1;
               rd_addr  = fcm2[FAW-1:0];
               state_in = S_RD2;
            end
         end
         S_RD2: begin
            as_in   = rd_data[2*SW-1:SW];
            ae_in   = rd_data[SW-1:0];
            wr_en   = 1'b1;
            wr_addr = fcm2[FAW-1:0];
            wr_data = (ek_ff == EK_CAT) ? {rd_data[2*SW-1:SW], be_ff} : {s_ff, e_ff};
            fc_in   = fcm1;
            k_in    = '0;
            state_in = S_EDGE;
         end
         S_EDGE: begin
            if (err_ff != rtn_pkg::ST_OK) begin
               state_in = ret_state;
            end else if (ecnt_ff >= 6'(rtn_pkg::EDGE_LIMIT)) begin
               err_in   = rtn_pkg::ST_OVERFLOW;
               state_in = ret_state;
            end else if (sink_ok) begin
               res.emit       = 1'b1;
               res.from_state = f_wide[OSW-1:0];
               res.to_state   = t_wide[OSW-1:0];
               res.symbol     = esym;
               res.is_epsilon = eeps;
               ecnt_in        = ecnt_ff + 6'd1;
               k_in           = k_ff + 2'd1;
               if (elast) begin
                  state_in = ret_state;
               end
            end
         end
         S_POST: begin
            if (item_ff.last) begin
               mode_in  = M_FIN;
               state_in = S_LOOP;
            end else begin
               state_in = S_FIN;
            end
         end
         S_CHKF: begin
            if (err_ff == rtn_pkg::ST_OK && fc_ff != FW'(1)) begin
               err_in = rtn_pkg::ST_MALFORMED;
            end
            rd_en    = 1'b1;
            rd_addr  = '0;
            state_in = S_RPT;
         end
         S_RPT: begin
            f_wide = {{OSW{1'b0}}, rd_data[2*SW-1:SW]};
            t_wide = {{OSW{1'b0}}, rd_data[SW-1:0]};
            if (sink_ok) begin
               res.emit   = 1'b1;
               res.kind   = 1'b1;
               res.status = err_ff;
               if (err_ff == rtn_pkg::ST_OK) begin
                  res.from_state = f_wide[OSW-1:0];
                  res.to_state   = t_wide[OSW-1:0];
               end
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (sink_ok) begin
               res.finish = 1'b1;
               state_in   = S_IDLE;
               if (item_ff.last) begin
                  opc_in = '0;
                  fc_in  = '0;
                  sc_in  = '0;
                  err_in = rtn_pkg::ST_OK;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         opc_ff   <= '0;
         fc_ff    <= '0;
         sc_ff    <= '0;
         err_ff   <= rtn_pkg::ST_OK;
         ecnt_ff  <= '0;
      end else begin
         state_ff <= state_in;
         opc_ff   <= opc_in;
         fc_ff    <= fc_in;
         sc_ff    <= sc_in;
         err_ff   <= err_in;
         ecnt_ff  <= ecnt_in;
      end
      mode_ff   <= mode_in;
      ek_ff     <= ek_in;
      cur_op_ff <= cur_op_in;
      item_ff   <= item_in;
      op_stk_ff <= op_stk_in;
      k_ff      <= k_in;
      s_ff      <= s_in;
      e_ff      <= e_in;
      as_ff     <= as_in;
      ae_ff     <= ae_in;
      bs_ff     <= bs_in;
      be_ff     <= be_in;
   end

endmodule

`default_nettype wire

// ===== rtl/regex_to_nfa_builder.sv =====
// ---------------------------------------------------------------------------
// regex_to_nfa_builder
// streaming thompson construction: regex characters in, nfa edges out
// ---------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  req_     in   req_valid/stall    ch, last
//  rsp_     out  rsp_valid/stall    kind, from_state, to_state, symbol,
//                                   is_epsilon, status, end_of_run
//
//  a character passes the sequencer steps take, classify, post and finish, plus
//  an edge step for a literal and an operator check (concat, ')', '|', '*')
//  each operator popped reads one fragment from the ram for a star or two for
//  concat and alternation, then emits its edges
//  the final report adds the closing drain and a ram read
//  reset is synchronous and clears all control state, no clearing pass;
//  a stalled rsp_ beat holds the sequencer at its next result
// ---------------------------------------------------------------------------
`default_nettype none

module regex_to_nfa_builder #(
   parameter int OP_STACK_DEPTH   = rtn_pkg::OP_STACK_DEPTH_DEF,
   parameter int FRAG_STACK_DEPTH = rtn_pkg::FRAG_STACK_DEPTH_DEF,
   parameter int MAX_STATES       = rtn_pkg::MAX_STATES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic [7:0]  req_ch,
   input  wire logic        req_last,
   output      logic        req_stall,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic        rsp_kind,
   output      logic [10:0] rsp_from_state,
   output      logic [10:0] rsp_to_state,
   output      logic [7:0]  rsp_symbol,
   output      logic        rsp_is_epsilon,
   output      logic [1:0]  rsp_status,
   output      logic        rsp_end_of_run
);

   rtn_pkg::item_type f_item, q_head;
   logic              f_push, q_full, q_not_empty, q_pop;
   logic              sink_ok;
   rtn_pkg::res_type  res;

   rtn_pkg::res_type  pend_ff, pend_in;
   logic              pend_v_ff, pend_v_in;
   rtn_pkg::res_type  out_ff, out_in;
   logic              out_eor_ff, out_eor_in;
   logic              out_v_ff, out_v_in;

   rtn_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ch    (req_ch),
      .req_last  (req_last),
      .req_stall (req_stall),
      .q_full    (q_full),
      .q_push    (f_push),
      .q_item    (f_item)
   );

   rtn_queue #(.DEPTH(rtn_pkg::QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (f_push),
      .push_item (f_item),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   rtn_back #(
      .OP_STACK_DEPTH   (OP_STACK_DEPTH),
      .FRAG_STACK_DEPTH (FRAG_STACK_DEPTH),
      .MAX_STATES       (MAX_STATES)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_not_empty),
      .q_head  (q_head),
      .q_pop   (q_pop),
      .sink_ok (sink_ok),
      .res     (res)
   );

   assign sink_ok = !pend_v_ff || !out_v_ff || !rsp_stall;

   always_comb begin
      pend_in    = pend_ff;
      pend_v_in  = pend_v_ff;
      out_in     = out_ff;
      out_eor_in = out_eor_ff;
      out_v_in   = out_v_ff;
      if (!rsp_stall) begin
         out_v_in = 1'b0;
      end
      if ((res.emit || res.finish) && pend_v_ff) begin
         out_in     = pend_ff;
         out_eor_in = res.finish;
         out_v_in   = 1'b1;
      end
      if (res.emit) begin
         pend_in   = res;
         pend_v_in = 1'b1;
      end else if (res.finish) begin
         pend_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         pend_v_ff <= pend_v_in;
         out_v_ff  <= out_v_in;
      end
      pend_ff    <= pend_in;
      out_ff     <= out_in;
      out_eor_ff <= out_eor_in;
   end

   assign rsp_valid      = out_v_ff;
   assign rsp_kind       = out_ff.kind;
   assign rsp_from_state = out_ff.from_state;
   assign rsp_to_state   = out_ff.to_state;
   assign rsp_symbol     = out_ff.symbol;
   assign rsp_is_epsilon = out_ff.is_epsilon;
   assign rsp_status     = out_ff.status;
   assign rsp_end_of_run = out_eor_ff;

   a_emit_finish_excl: assert property (@(posedge clock) disable iff (reset)
      !(res.emit && res.finish))
      else $error("emit and finish together");

   a_sink_ok: assert property (@(posedge clock) disable iff (reset)
      (res.emit || res.finish) |-> sink_ok)
      else $error("result pushed into a full output stage");

   a_report_ends_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind) |-> rsp_end_of_run)
      else $error("final report without end of run");

   a_status_only_on_report: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_kind) |-> (rsp_status == rtn_pkg::ST_OK))
      else $error("status on an edge beat");

endmodule

`default_nettype wire
